[design/ptt_pkg.sv]
// Package for the periodic timer table: command and status codes, field
// widths and the packed layout of one table entry.
// Depends on nothing; imported by periodic_timer_table_core.
package ptt_pkg;

	localparam int KIND_W     = 3;
	localparam int STATUS_W   = 2;
	localparam int ID_W       = 32;
	localparam int US_W       = 32;
	localparam int INTERVAL_W = 15;
	localparam int ELAPSED_W  = 16;

	// Only this many expiries are reported per tick.
	localparam int MAX_RESULTS = 16;
	localparam int FIRED_W     = $clog2(MAX_RESULTS + 1);

	localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = {INTERVAL_W{1'b1}};
	localparam logic [ELAPSED_W-1:0]  ELAPSED_MAX  = {ELAPSED_W{1'b1}};

	localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RESET   = 3'd2;
	localparam logic [KIND_W-1:0] KIND_KILL    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_KILLALL = 3'd4;
	localparam logic [KIND_W-1:0] KIND_ENABLE  = 3'd5;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ADDED    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]       id;
		logic [INTERVAL_W-1:0] interval;
		logic [ELAPSED_W-1:0]  elapsed;
		logic                  enabled;
	} entry_t;

endpackage

[design/periodic_timer_table_core.sv]
// Periodic timer table: entry memory, scan and search sequencer, interval
// divider and output register.
// Depends on ptt_pkg.

// Usage:
// Commands enter on the cmd channel (kind, timer_id, interval_us, enable_flag)
// and results leave on the res channel (fired_id, is_expiry, status, last),
// both with valid/ready. The block takes one command at a time; cmd_ready is
// high only while the sequencer is idle, even when a result still waits in
// the output register.
// Sequence: every table entry visited passes a memory read step, then an
// evaluate and write back step; a tick visits every live entry, then a closing
// step, and a search visits each entry up to the match. Appending a new
// entry forms the product of interval_us with the reciprocal of TICK_US
// on one shared 32 x 17 multiplier, low half then high half, and then
// writes. A kill moves every entry behind the removed one down by one place.
// Kill all clears the count and answers directly; kinds 6 and 7 are dropped at once.
// A tick gives one item per fired timer up to MAX_RESULTS, with last on the
// final one, none when nothing fires; kinds 1 to 5 give one item, last set.
// When the receiver stalls, the sequencer waits in place before it loads the
// next result, so no item is ever lost. Reset empties the table at once; the
// entry memory itself is not cleared and needs no clearing pass.
module periodic_timer_table_core #(
	parameter int TABLE_DEPTH = 16,
	parameter int TICK_US     = 200000
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  logic [ptt_pkg::KIND_W-1:0]     kind,
	input  logic signed [ptt_pkg::ID_W-1:0] timer_id,
	input  logic [ptt_pkg::US_W-1:0]       interval_us,
	input  logic                           enable_flag,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic signed [ptt_pkg::ID_W-1:0] fired_id,
	output logic                           is_expiry,
	output logic [ptt_pkg::STATUS_W-1:0]   status,
	output logic                           last
);
	import ptt_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam int DL     = $clog2(TICK_US);
	localparam int DS     = US_W + DL;
	localparam int MB_W   = 17;
	localparam int PROD_W = US_W + MB_W;
	localparam int ACC_W  = US_W + 2 * MB_W;
	// Rounded-up reciprocal of the tick length; with this shift the quotient is
	// exact for every 32-bit dividend.
	localparam logic [63:0] RECIP = ((64'd1 << DS) + 64'(TICK_US) - 64'd1) / 64'(TICK_US);
	localparam logic [MB_W-1:0] RECIP_LO = RECIP[MB_W-1:0];
	localparam logic [MB_W-1:0] RECIP_HI = RECIP[2*MB_W-1:MB_W];

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_EV   = 4'd2;
	localparam logic [3:0] ST_TEND = 4'd3;
	localparam logic [3:0] ST_DIV  = 4'd4;
	localparam logic [3:0] ST_APP  = 4'd5;
	localparam logic [3:0] ST_KRD  = 4'd6;
	localparam logic [3:0] ST_KEV  = 4'd7;
	localparam logic [3:0] ST_RESP = 4'd8;

	logic [3:0]          state_q, state_d;
	logic [KIND_W-1:0]   kind_q, kind_d;
	logic [ID_W-1:0]     id_q, id_d;
	logic                en_q, en_d;
	logic [US_W-1:0]     dvd_q, dvd_d;
	logic [ACC_W-1:0]    acc_q, acc_d;
	logic                mul_hi_q, mul_hi_d;
	logic [CW-1:0]       idx_q, idx_d;
	logic [CW-1:0]       count_q, count_d;
	logic [FIRED_W-1:0]  nfired_q, nfired_d;
	logic                pend_valid_q, pend_valid_d;
	logic [ID_W-1:0]     pend_id_q, pend_id_d;
	logic [STATUS_W-1:0] status_q, status_d;

	logic                out_valid_q;
	logic [ID_W-1:0]     out_id_q;
	logic                out_exp_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_last_q;

	logic                out_load;
	logic [ID_W-1:0]     ld_id;
	logic                ld_exp;
	logic [STATUS_W-1:0] ld_status;
	logic                ld_last;

	entry_t              tbl_mem_q [TABLE_DEPTH];
	entry_t              rd_data_q;
	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [IW-1:0]       mem_raddr;
	entry_t              mem_wdata;

	logic                out_free;
	logic                cmd_fire;
	logic [CW-1:0]       idx_inc;
	logic                last_ent;
	logic                fire;
	logic                id_hit;
	logic                report;
	logic [MB_W-1:0]     mul_b;
	logic [PROD_W-1:0]   mul_p;
	logic [ACC_W-1:0]    quo_full;
	logic [INTERVAL_W-1:0] new_interval;

	assign out_free  = !out_valid_q || res_ready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign idx_inc   = idx_q + CW'(1);
	assign last_ent  = (idx_inc == count_q);
	assign fire      = rd_data_q.enabled && (rd_data_q.elapsed == {1'b0, rd_data_q.interval});
	assign id_hit    = (rd_data_q.id == id_q);
	assign report    = fire && (nfired_q < FIRED_W'(MAX_RESULTS));

	// The product with the reciprocal is built from its low half, then its high
	// half, on the same multiplier; the quotient is that product shifted down.
	assign mul_b    = mul_hi_q ? RECIP_HI : RECIP_LO;
	assign mul_p    = dvd_q * mul_b;
	assign quo_full = acc_q >> DS;
	assign new_interval = (|quo_full[ACC_W-1:INTERVAL_W]) ? INTERVAL_MAX :
		quo_full[INTERVAL_W-1:0];

	always_comb begin
		state_d      = state_q;
		kind_d       = kind_q;
		id_d         = id_q;
		en_d         = en_q;
		dvd_d        = dvd_q;
		acc_d        = acc_q;
		mul_hi_d     = mul_hi_q;
		idx_d        = idx_q;
		count_d      = count_q;
		nfired_d     = nfired_q;
		pend_valid_d = pend_valid_q;
		pend_id_d    = pend_id_q;
		status_d     = status_q;
		out_load     = 1'b0;
		ld_id        = pend_id_q;
		ld_exp       = 1'b1;
		ld_status    = STAT_OK;
		ld_last      = 1'b0;
		mem_we       = 1'b0;
		mem_waddr    = idx_q[IW-1:0];
		mem_raddr    = idx_q[IW-1:0];
		mem_wdata    = rd_data_q;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_fire) begin
					kind_d    = kind;
					id_d      = timer_id;
					en_d      = enable_flag;
					dvd_d     = interval_us;
					acc_d     = '0;
					mul_hi_d  = 1'b0;
					idx_d     = '0;
					nfired_d  = '0;
					case (kind) inside
						KIND_TICK: begin
							state_d = (count_q == '0) ? ST_IDLE : ST_RD;
						end
						KIND_SET, KIND_RESET, KIND_KILL, KIND_ENABLE: begin
							if (count_q != '0) begin
								state_d = ST_RD;
							end else if (kind == KIND_SET) begin
								state_d = ST_DIV;
							end else begin
								status_d = STAT_NOTFOUND;
								state_d  = ST_RESP;
							end
						end
						KIND_KILLALL: begin
							status_d = (count_q != '0) ? STAT_OK : STAT_NOTFOUND;
							count_d  = '0;
							state_d  = ST_RESP;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_RD: begin
				state_d = ST_EV;
			end
			ST_EV: begin
				if (kind_q == KIND_TICK) begin
					// A new expiry pushes the held one out, so wait for room first.
					if (!(report && pend_valid_q && !out_free)) begin
						mem_we = 1'b1;
						if (fire) begin
							mem_wdata.elapsed = '0;
						end else if (rd_data_q.elapsed != ELAPSED_MAX) begin
							mem_wdata.elapsed = rd_data_q.elapsed + ELAPSED_W'(1);
						end
						if (report) begin
							nfired_d     = nfired_q + FIRED_W'(1);
							pend_valid_d = 1'b1;
							pend_id_d    = rd_data_q.id;
							out_load     = pend_valid_q;
						end
						if (last_ent) begin
							state_d = ST_TEND;
						end else begin
							idx_d   = idx_inc;
							state_d = ST_RD;
						end
					end
				end else if (id_hit) begin
					status_d = STAT_OK;
					state_d  = ST_RESP;
					case (kind_q) inside
						KIND_SET, KIND_RESET: begin
							mem_we            = 1'b1;
							mem_wdata.elapsed = '0;
						end
						KIND_ENABLE: begin
							mem_we            = 1'b1;
							mem_wdata.enabled = en_q;
						end
						KIND_KILL: begin
							state_d = ST_KRD;
						end
						default: begin
							state_d = ST_RESP;
						end
					endcase
				end else if (last_ent) begin
					if (kind_q != KIND_SET) begin
						status_d = STAT_NOTFOUND;
						state_d  = ST_RESP;
					end else if (count_q < DEPTH_C) begin
						state_d = ST_DIV;
					end else begin
						status_d = STAT_FULL;
						state_d  = ST_RESP;
					end
				end else begin
					idx_d   = idx_inc;
					state_d = ST_RD;
				end
			end
			ST_TEND: begin
				if (!pend_valid_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					out_load     = 1'b1;
					ld_last      = 1'b1;
					pend_valid_d = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			ST_DIV: begin
				mul_hi_d = 1'b1;
				if (!mul_hi_q) begin
					acc_d = ACC_W'(mul_p);
				end else begin
					acc_d   = acc_q + {mul_p, {MB_W{1'b0}}};
					state_d = ST_APP;
				end
			end
			ST_APP: begin
				mem_we            = 1'b1;
				mem_waddr         = count_q[IW-1:0];
				mem_wdata.id       = id_q;
				mem_wdata.interval = new_interval;
				mem_wdata.elapsed  = '0;
				mem_wdata.enabled  = 1'b1;
				count_d           = count_q + CW'(1);
				status_d          = STAT_ADDED;
				state_d           = ST_RESP;
			end
			ST_KRD: begin
				// Close the gap: move each later entry down by one place.
				if (idx_inc >= count_q) begin
					count_d  = count_q - CW'(1);
					status_d = STAT_OK;
					state_d  = ST_RESP;
				end else begin
					mem_raddr = idx_inc[IW-1:0];
					state_d   = ST_KEV;
				end
			end
			ST_KEV: begin
				mem_we  = 1'b1;
				idx_d   = idx_inc;
				state_d = ST_KRD;
			end
			ST_RESP: begin
				if (out_free) begin
					out_load  = 1'b1;
					ld_id     = '0;
					ld_exp    = 1'b0;
					ld_status = status_q;
					ld_last   = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			pend_valid_q <= pend_valid_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		kind_q    <= kind_d;
		id_q      <= id_d;
		en_q      <= en_d;
		dvd_q     <= dvd_d;
		acc_q     <= acc_d;
		mul_hi_q  <= mul_hi_d;
		idx_q     <= idx_d;
		nfired_q  <= nfired_d;
		pend_id_q <= pend_id_d;
		status_q  <= status_d;
		if (out_load) begin
			out_id_q     <= ld_id;
			out_exp_q    <= ld_exp;
			out_status_q <= ld_status;
			out_last_q   <= ld_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= tbl_mem_q[mem_raddr];
	end

	assign res_valid = out_valid_q;
	assign fired_id  = out_id_q;
	assign is_expiry = out_exp_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("entry count exceeds table depth");

	a_write_live: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) <= count_q))
		else $error("table write beyond the live entries");

	a_fired_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EV && kind_q == KIND_TICK) |-> (nfired_q <= FIRED_W'(MAX_RESULTS)))
		else $error("more expiries reported than allowed");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("held expiry left behind at end of tick");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && kind != KIND_TICK && kind <= KIND_ENABLE) |=> !cmd_ready)
		else $error("command taken while another is in progress");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for periodic_timer_table_core: a directed command table, then random commands
// under four handshake idling phases, all checked against a timer table predictor.
// Depends on ptt_pkg and periodic_timer_table_core.
module tb_top;
	import ptt_pkg::*;

	localparam int TABLE_DEPTH      = 16;
	localparam int TICK_US          = 200000;
	localparam int POOL_SIZE        = 24;
	localparam int RANDOM_PER_PHASE = 105;
	localparam int AWAIT_DEPTH      = 64;
	localparam int ROW_DEPTH        = 64;

	// The two kind codes that the block drops without a result.
	localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic                expiry;
		logic [STATUS_W-1:0] status;
		logic                last;
	} result_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [ID_W-1:0]     id;
		logic [US_W-1:0]     us;
		logic                en;
		logic [16:0]         rep;
		logic                typed;
		logic [STATUS_W-1:0] stat;
	} row_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cmd_valid;
	logic                     cmd_ready;
	logic [KIND_W-1:0]        kind;
	logic signed [ID_W-1:0]   timer_id;
	logic [US_W-1:0]          interval_us;
	logic                     enable_flag;
	logic                     res_valid;
	logic                     res_ready;
	logic signed [ID_W-1:0]   fired_id;
	logic                     is_expiry;
	logic [STATUS_W-1:0]      status;
	logic                     last;

	// Status typed into the directed table travels beside the item it belongs to.
	logic                     drv_typed;
	logic [STATUS_W-1:0]      drv_stat;

	int send_idle_pct;
	int stall_pct;
	int n_mismatch;
	int n_commands;
	int n_ticks;
	int n_results;
	int n_expiries;
	int n_full;

	// Predicted contents of the timer table.
	logic [ID_W-1:0]       tbl_id       [TABLE_DEPTH];
	logic [INTERVAL_W-1:0] tbl_interval [TABLE_DEPTH];
	logic [ELAPSED_W-1:0]  tbl_elapsed  [TABLE_DEPTH];
	logic                  tbl_en       [TABLE_DEPTH];
	int                    tbl_count;

	// Results still to come, kept in a ring in arrival order.
	result_t               awaited_results [AWAIT_DEPTH];
	int                    await_wr = 0;
	int                    await_rd = 0;
	row_t                  directed_rows [ROW_DEPTH];
	int                    n_rows;
	logic [ID_W-1:0]       id_pool [POOL_SIZE];

	periodic_timer_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.TICK_US    (TICK_US)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.kind       (kind),
		.timer_id   (timer_id),
		.interval_us(interval_us),
		.enable_flag(enable_flag),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.fired_id   (fired_id),
		.is_expiry  (is_expiry),
		.status     (status),
		.last       (last)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		n_mismatch++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic queue_result(input result_t r);
		awaited_results[await_wr % AWAIT_DEPTH] = r;
		await_wr++;
	endtask

	function automatic int find_timer(input logic [ID_W-1:0] id);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_id[i] == id) return i;
		end
		return -1;
	endfunction

	// Applies one accepted item to the predicted table and queues the results it causes.
	task automatic run_timer_table(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
			input logic [US_W-1:0] us, input logic en, input logic typed,
			input logic [STATUS_W-1:0] typed_stat);
		int pos;
		int i;
		int n_fire;
		logic [US_W-1:0] q;
		logic [STATUS_W-1:0] st;
		logic [ID_W-1:0] fires [MAX_RESULTS];
		pos = find_timer(id);
		st = STAT_NOTFOUND;
		n_fire = 0;
		case (k)
			KIND_TICK: begin
				for (i = 0; i < tbl_count; i++) begin
					if (tbl_en[i] && tbl_elapsed[i] == {1'b0, tbl_interval[i]}) begin
						tbl_elapsed[i] = '0;
						if (n_fire < MAX_RESULTS) begin
							fires[n_fire] = tbl_id[i];
							n_fire++;
						end
					end else if (tbl_elapsed[i] != ELAPSED_MAX) begin
						tbl_elapsed[i] = tbl_elapsed[i] + 1'b1;
					end
				end
				for (i = 0; i < n_fire; i++) begin
					queue_result({fires[i], 1'b1, STAT_OK, 1'(i == n_fire - 1)});
				end
				return;
			end
			KIND_SET: begin
				if (pos >= 0) begin
					tbl_elapsed[pos] = '0;
					st = STAT_OK;
				end else if (tbl_count < TABLE_DEPTH) begin
					q = us / US_W'(TICK_US);
					if (q > INTERVAL_MAX) q = INTERVAL_MAX;
					tbl_id[tbl_count]       = id;
					tbl_interval[tbl_count] = q[INTERVAL_W-1:0];
					tbl_elapsed[tbl_count]  = '0;
					tbl_en[tbl_count]       = 1'b1;
					tbl_count++;
					st = STAT_ADDED;
				end else begin
					st = STAT_FULL;
					n_full++;
				end
			end
			KIND_RESET: begin
				if (pos >= 0) begin
					tbl_elapsed[pos] = '0;
					st = STAT_OK;
				end
			end
			KIND_KILL: begin
				if (pos >= 0) begin
					for (i = pos; i < tbl_count - 1; i++) begin
						tbl_id[i]       = tbl_id[i+1];
						tbl_interval[i] = tbl_interval[i+1];
						tbl_elapsed[i]  = tbl_elapsed[i+1];
						tbl_en[i]       = tbl_en[i+1];
					end
					tbl_count--;
					st = STAT_OK;
				end
			end
			KIND_KILLALL: begin
				st = (tbl_count > 0) ? STAT_OK : STAT_NOTFOUND;
				tbl_count = 0;
			end
			KIND_ENABLE: begin
				if (pos >= 0) begin
					tbl_en[pos] = en;
					st = STAT_OK;
				end
			end
			default: return;
		endcase
		queue_result({{ID_W{1'b0}}, 1'b0, typed ? typed_stat : st, 1'b1});
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				got = {fired_id, is_expiry, status, last};
				n_results++;
				if (is_expiry) n_expiries++;
				if (await_wr == await_rd) begin
					flag_mismatch($sformatf("result %h arrived with nothing awaited", got));
				end else begin
					want = awaited_results[await_rd % AWAIT_DEPTH];
					await_rd++;
					if (got.id !== want.id)
						flag_mismatch($sformatf("fired_id %h, expected %h", got.id, want.id));
					if (got.expiry !== want.expiry)
						flag_mismatch($sformatf("is_expiry %b, expected %b",
							got.expiry, want.expiry));
					if (got.status !== want.status)
						flag_mismatch($sformatf("status %0d, expected %0d",
							got.status, want.status));
					if (got.last !== want.last)
						flag_mismatch($sformatf("last %b, expected %b", got.last, want.last));
				end
			end
			if (cmd_valid && cmd_ready) begin
				n_commands++;
				if (kind == KIND_TICK) n_ticks++;
				run_timer_table(kind, timer_id, interval_us, enable_flag, drv_typed, drv_stat);
			end
		end
	end

	always @(posedge clk) begin
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic send_command(input row_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid   <= 1'b1;
		kind        <= r.kind;
		timer_id    <= r.id;
		interval_us <= r.us;
		enable_flag <= r.en;
		drv_typed   <= r.typed;
		drv_stat    <= r.stat;
		do @(posedge clk); while (!cmd_ready);
	endtask

	task automatic add_row(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] id,
			input logic [US_W-1:0] us, input logic en, input int rep, input logic typed,
			input logic [STATUS_W-1:0] stat);
		directed_rows[n_rows] = {k, id, us, en, 17'(rep), typed, stat};
		n_rows++;
	endtask

	// Mostly commands on a small pool of ids with short periods, so that lookups hit,
	// the table fills up and timers fire; the rest is arbitrary ids and periods.
	task automatic make_random_command(output row_t r);
		int pick;
		pick = $urandom_range(99);
		r = '0;
		r.rep = 17'd1;
		if (pick < 38) r.kind = KIND_TICK;
		else if (pick < 62) r.kind = KIND_SET;
		else if (pick < 70) r.kind = KIND_RESET;
		else if (pick < 80) r.kind = KIND_KILL;
		else if (pick < 82) r.kind = KIND_KILLALL;
		else if (pick < 93) r.kind = KIND_ENABLE;
		else if (pick < 97) r.kind = $urandom_range(1) ? KIND_SPARE_6 : KIND_SPARE_7;
		else r.kind = KIND_SET;
		r.id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE - 1)] : $urandom();
		if ($urandom_range(99) < 75)
			r.us = $urandom_range(6) * TICK_US + $urandom_range(TICK_US - 1);
		else
			r.us = $urandom();
		r.en = ($urandom_range(99) < 70);
	endtask

	initial begin
		row_t r;
		int sent;
		cmd_valid     <= 1'b0;
		kind          <= KIND_TICK;
		timer_id      <= '0;
		interval_us   <= '0;
		enable_flag   <= 1'b0;
		drv_typed     <= 1'b0;
		drv_stat      <= STAT_OK;
		res_ready     <= 1'b0;
		arst_n        <= 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		n_mismatch    = 0;
		n_commands    = 0;
		n_ticks       = 0;
		n_results     = 0;
		n_expiries    = 0;
		n_full        = 0;
		tbl_count     = 0;
		n_rows        = 0;

		id_pool[0] = 32'h8000_0000;
		id_pool[1] = 32'h7FFF_FFFF;
		id_pool[2] = 32'h0000_0000;
		id_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < POOL_SIZE; i++) id_pool[i] = $urandom();

		// Empty table: nothing fires and every lookup misses.
		add_row(KIND_TICK,    32'd0,          32'd0,          1'b0, 1, 1'b0, STAT_OK);
		add_row(KIND_KILLALL, 32'd0,          32'd0,          1'b0, 1, 1'b1, STAT_NOTFOUND);
		add_row(KIND_RESET,   32'd5,          32'd0,          1'b0, 1, 1'b1, STAT_NOTFOUND);
		add_row(KIND_KILL,    32'd5,          32'd0,          1'b0, 1, 1'b1, STAT_NOTFOUND);
		add_row(KIND_ENABLE,  32'd5,          32'd0,          1'b1, 1, 1'b1, STAT_NOTFOUND);
		// Extreme ids and periods, including periods just under and at one tick.
		add_row(KIND_SET,     32'h8000_0000,  32'd0,          1'b0, 1, 1'b1, STAT_ADDED);
		add_row(KIND_SET,     32'h7FFF_FFFF,  32'hFFFF_FFFF,  1'b1, 1, 1'b1, STAT_ADDED);
		add_row(KIND_SET,     32'd0,          32'd199999,     1'b0, 1, 1'b1, STAT_ADDED);
		add_row(KIND_SET,     32'hFFFF_FFFF,  32'd200000,     1'b0, 1, 1'b1, STAT_ADDED);
		add_row(KIND_TICK,    32'd0,          32'd0,          1'b0, 2, 1'b0, STAT_OK);
		add_row(KIND_SET,     32'h8000_0000,  32'd12345,      1'b0, 1, 1'b1, STAT_OK);
		// A disabled timer keeps counting past its period and then never matches until it is reset.
		add_row(KIND_ENABLE,  32'd0,          32'd0,          1'b0, 1, 1'b1, STAT_OK);
		add_row(KIND_TICK,    32'd0,          32'd0,          1'b0, 3, 1'b0, STAT_OK);
		add_row(KIND_ENABLE,  32'd0,          32'd0,          1'b1, 1, 1'b1, STAT_OK);
		add_row(KIND_TICK,    32'd0,          32'd0,          1'b0, 2, 1'b0, STAT_OK);
		add_row(KIND_RESET,   32'd0,          32'd0,          1'b0, 1, 1'b1, STAT_OK);
		add_row(KIND_TICK,    32'd0,          32'd0,          1'b0, 1, 1'b0, STAT_OK);
		add_row(KIND_KILL,    32'h8000_0000,  32'd0,          1'b0, 1, 1'b1, STAT_OK);
		add_row(KIND_SPARE_6, 32'hA5A5_5A5A,  32'h5A5A_A5A5,  1'b1, 1, 1'b0, STAT_OK);
		add_row(KIND_SPARE_7, 32'h5A5A_A5A5,  32'hA5A5_5A5A,  1'b0, 1, 1'b0, STAT_OK);
		add_row(KIND_KILLALL, 32'd0,          32'd0,          1'b0, 1, 1'b1, STAT_OK);
		// Fill the table with timers that all fire on the next tick, then overflow it.
		add_row(KIND_SET,     32'h0000_1000,  32'd0,          1'b0, 16, 1'b1, STAT_ADDED);
		add_row(KIND_SET,     32'h5555_AAAA,  32'd0,          1'b0, 1, 1'b1, STAT_FULL);
		add_row(KIND_TICK,    32'd0,          32'd0,          1'b0, 1, 1'b0, STAT_OK);
		add_row(KIND_KILLALL, 32'd0,          32'd0,          1'b0, 1, 1'b1, STAT_OK);
		// A disabled two-tick timer overruns its period; enabled again, it stays silent.
		add_row(KIND_SET,     32'h600D_0001,  32'd400000,     1'b0, 1, 1'b1, STAT_ADDED);
		add_row(KIND_ENABLE,  32'h600D_0001,  32'd0,          1'b0, 1, 1'b1, STAT_OK);
		add_row(KIND_TICK,    32'd0,          32'd0,          1'b0, 6, 1'b0, STAT_OK);
		add_row(KIND_ENABLE,  32'h600D_0001,  32'd0,          1'b1, 1, 1'b1, STAT_OK);
		add_row(KIND_TICK,    32'd0,          32'd0,          1'b0, 4, 1'b0, STAT_OK);
		add_row(KIND_RESET,   32'h600D_0001,  32'd0,          1'b0, 1, 1'b1, STAT_OK);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 14; stall_pct = 14; end
			endcase
			if (phase == 0) begin
				for (int j = 0; j < n_rows; j++) begin
					for (int k = 0; k < directed_rows[j].rep; k++) begin
						r = directed_rows[j];
						r.id = directed_rows[j].id + k;
						send_command(r);
					end
				end
			end
			sent = 0;
			while (sent < RANDOM_PER_PHASE) begin
				make_random_command(r);
				send_command(r);
				if (r.kind <= KIND_ENABLE) sent++;
			end
		end
		cmd_valid <= 1'b0;

		while (await_wr != await_rd) @(posedge clk);
		repeat (80) @(posedge clk);

		$display("Ran %0d commands (%0d ticks) through four idling phases.", n_commands, n_ticks);
		$display("Checked %0d results: %0d expiries, %0d full-table refusals.",
			n_results, n_expiries, n_full);
		if (n_mismatch == 0) begin
			$display("PASS periodic_timer_table_core");
		end else begin
			$display("FAIL periodic_timer_table_core");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("FAIL periodic_timer_table_core");
		$finish;
	end

endmodule
